// ===== src/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, constants and the stage types shared by the normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

   localparam int COORD_BITS = 16;
   localparam int TAG_BITS   = 10;
   localparam int UNIT_BITS  = 16;
   localparam int EDGE_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * EDGE_W;
   localparam int CROSS_W    = 2 * COORD_BITS + 3;
   localparam int MAG_W      = CROSS_W - 1;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int DREM_W     = ROOT_W + 1;
   localparam int Q_BITS     = UNIT_BITS;

   localparam logic [UNIT_BITS-1:0] UNIT_MAX = {1'b0, {(UNIT_BITS-1){1'b1}}};

   // One stage of the square root chain
   typedef struct packed {
      logic                           valid;
      logic [TAG_BITS-1:0]            tag;
      logic                           degen;
      logic [2:0]                     neg;
      logic [2:0][MAG_W-1:0]          mag;
      logic [SUM_W-1:0]               rad;
      logic [REM_W-1:0]               rem;
      logic [ROOT_W-1:0]              root;
   } tun_sqrt_type;

   // One stage of the division chain, three lanes sharing one divisor
   typedef struct packed {
      logic                           valid;
      logic [TAG_BITS-1:0]            tag;
      logic                           degen;
      logic [2:0]                     neg;
      logic [ROOT_W-1:0]              len;
      logic [2:0][DREM_W-1:0]         rem;
      logic [2:0][Q_BITS-1:0]         q;
   } tun_div_type;

endpackage

// ===== src/tun_front.sv =====
// ----------------------------------------------------------------------------
// Triangle normal front end
// Edges, cross product, magnitudes and squared length in five stages.
// ----------------------------------------------------------------------------
module tun_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [tun_pkg::TAG_BITS-1:0]             in_tag,
   input  logic [2:0][tun_pkg::COORD_BITS-1:0]      va,
   input  logic [2:0][tun_pkg::COORD_BITS-1:0]      vb,
   input  logic [2:0][tun_pkg::COORD_BITS-1:0]      vc,
   output tun_pkg::tun_sqrt_type                    out
);
   import tun_pkg::*;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic [TAG_BITS-1:0]       t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [EDGE_W-1:0]  e1_ff [3];
   logic signed [EDGE_W-1:0]  e2_ff [3];
   logic signed [PROD_W-1:0]  pa_ff [3];
   logic signed [PROD_W-1:0]  pb_ff [3];
   logic [CROSS_W-1:0]        n_ff [3];
   logic [2:0]                neg_ff;
   logic [2:0][MAG_W-1:0]     mag_ff;
   logic [SQ_W-1:0]           sq_ff [3];
   logic                      degen_ff;
   tun_sqrt_type              out_ff;
   logic [CROSS_W-1:0]        nabs_in [3];

   // Magnitudes of the cross components
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nabs_in[i] = n_ff[i][CROSS_W-1] ? (~n_ff[i] + 1'b1) : n_ff[i];
      end
   end

   // Advance all stages together; only the stage valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         out_ff.valid <= v4_ff;
      end
      if (en) begin
         t1_ff <= in_tag;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= {vb[i][COORD_BITS-1], vb[i]} - {va[i][COORD_BITS-1], va[i]};
            e2_ff[i] <= {vc[i][COORD_BITS-1], vc[i]} - {va[i][COORD_BITS-1], va[i]};
            pa_ff[i] <= e1_ff[(i+1)%3] * e2_ff[(i+2)%3];
            pb_ff[i] <= e1_ff[(i+2)%3] * e2_ff[(i+1)%3];
            n_ff[i]  <= {pa_ff[i][PROD_W-1], pa_ff[i]} - {pb_ff[i][PROD_W-1], pb_ff[i]};
            neg_ff[i] <= n_ff[i][CROSS_W-1];
            mag_ff[i] <= nabs_in[i][MAG_W-1:0];
            sq_ff[i]  <= nabs_in[i][MAG_W-1:0] * nabs_in[i][MAG_W-1:0];
         end
         degen_ff   <= (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
         out_ff.tag   <= t4_ff;
         out_ff.degen <= degen_ff;
         out_ff.neg   <= neg_ff;
         out_ff.mag   <= mag_ff;
         out_ff.rad   <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
         out_ff.rem   <= '0;
         out_ff.root  <= '0;
      end
   end

   assign out = out_ff;

endmodule

// ===== src/tun_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit per cell from two radicand bits (restoring method).
// ----------------------------------------------------------------------------
module tun_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  tun_pkg::tun_sqrt_type   din,
   output tun_pkg::tun_sqrt_type   dout
);
   import tun_pkg::*;

   tun_sqrt_type       dout_ff;
   logic [REM_W-1:0]   rem_sh;
   logic [REM_W-1:0]   trial;
   logic               ge;

   // Bring down two radicand bits and test the trial root
   always_comb begin
      rem_sh = {din.rem[REM_W-3:0], din.rad[SUM_W-1 -: 2]};
      trial  = {1'b0, din.root, 2'b01};
      ge     = rem_sh >= trial;
   end

   // Advance the cell; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff.valid <= 1'b0;
      end else if (en) begin
         dout_ff.valid <= din.valid;
      end
      if (en) begin
         dout_ff.tag   <= din.tag;
         dout_ff.degen <= din.degen;
         dout_ff.neg   <= din.neg;
         dout_ff.mag   <= din.mag;
         dout_ff.rad   <= {din.rad[SUM_W-3:0], 2'b00};
         dout_ff.rem   <= ge ? (rem_sh - trial) : rem_sh;
         dout_ff.root  <= {din.root[ROOT_W-2:0], ge};
      end
   end

   assign dout = dout_ff;

endmodule

// ===== src/tun_div_cell.sv =====
// ----------------------------------------------------------------------------
// Division cell
// Resolves one quotient bit for each of the three normal components.
// ----------------------------------------------------------------------------
module tun_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  tun_pkg::tun_div_type   din,
   output tun_pkg::tun_div_type   dout
);
   import tun_pkg::*;

   tun_div_type         dout_ff;
   logic [2:0]          ge;
   logic [DREM_W-1:0]   diff [3];

   // Compare and subtract per lane
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ge[i]   = din.rem[i] >= {1'b0, din.len};
         diff[i] = ge[i] ? (din.rem[i] - {1'b0, din.len}) : din.rem[i];
      end
   end

   // Advance the cell; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff.valid <= 1'b0;
      end else if (en) begin
         dout_ff.valid <= din.valid;
      end
      if (en) begin
         dout_ff.tag   <= din.tag;
         dout_ff.degen <= din.degen;
         dout_ff.neg   <= din.neg;
         dout_ff.len   <= din.len;
         for (int i = 0; i < 3; i++) begin
            dout_ff.rem[i] <= {diff[i][DREM_W-2:0], 1'b0};
            dout_ff.q[i]   <= {din.q[i][Q_BITS-2:0], ge[i]};
         end
      end
   end

   assign dout = dout_ff;

endmodule

// ===== src/triangle_unit_normal.sv =====
// ----------------------------------------------------------------------------
// Triangle unit normal
// Throughput: one transaction per cycle while no finished response is held
//   by rsp_stall; the 35-cell root chain and the 16-cell quotient chain
//   each advance one triangle per cycle.
// Reset: synchronous; clears every stage valid bit, payload is not reset.
// ----------------------------------------------------------------------------
module triangle_unit_normal (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tun_pkg::TAG_BITS-1:0]       req_tri_tag,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_ax,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_ay,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_az,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_bx,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_by,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_bz,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_cx,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_cy,
   input  logic [tun_pkg::COORD_BITS-1:0]     req_cz,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tun_pkg::TAG_BITS-1:0]       rsp_out_tag,
   output logic [tun_pkg::UNIT_BITS-1:0]      rsp_unit_x,
   output logic [tun_pkg::UNIT_BITS-1:0]      rsp_unit_y,
   output logic [tun_pkg::UNIT_BITS-1:0]      rsp_unit_z,
   output logic                               rsp_degenerate
);
   import tun_pkg::*;

   logic                          en;
   logic                          valid_ff;
   logic [TAG_BITS-1:0]           tag_ff;
   logic [2:0][UNIT_BITS-1:0]     unit_ff;
   logic                          degen_ff;
   logic [2:0][UNIT_BITS-1:0]     unit_in;
   logic [UNIT_BITS-1:0]          sat_mag;
   tun_sqrt_type                  sq_chain [ROOT_W+1];
   tun_div_type                   dv_chain [Q_BITS+1];
   tun_div_type                   dv_head;
   tun_div_type                   dv_tail;

   // Advance the whole pipeline unless a finished response is held
   assign en        = !(valid_ff && rsp_stall);
   assign req_stall = !en;

   tun_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_tag   (req_tri_tag),
      .va       ({req_az, req_ay, req_ax}),
      .vb       ({req_bz, req_by, req_bx}),
      .vc       ({req_cz, req_cy, req_cx}),
      .out      (sq_chain[0])
   );

   // Square root chain, one root bit per cell
   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      tun_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .din   (sq_chain[g]),
         .dout  (sq_chain[g+1])
      );
   end

   // Seed the quotient chain with the component magnitudes and the length
   always_comb begin
      dv_head.valid = sq_chain[ROOT_W].valid;
      dv_head.tag   = sq_chain[ROOT_W].tag;
      dv_head.degen = sq_chain[ROOT_W].degen;
      dv_head.neg   = sq_chain[ROOT_W].neg;
      dv_head.len   = sq_chain[ROOT_W].root;
      for (int i = 0; i < 3; i++) begin
         dv_head.rem[i] = DREM_W'(sq_chain[ROOT_W].mag[i]);
         dv_head.q[i]   = '0;
      end
   end

   assign dv_chain[0] = dv_head;

   // Quotient chain, one bit per cell for all three lanes
   for (genvar g = 0; g < Q_BITS; g++) begin : g_div
      tun_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .din   (dv_chain[g]),
         .dout  (dv_chain[g+1])
      );
   end

   assign dv_tail = dv_chain[Q_BITS];

   // Saturate, apply sign, zero the degenerate case
   always_comb begin
      sat_mag = '0;
      for (int i = 0; i < 3; i++) begin
         sat_mag = dv_tail.q[i][Q_BITS-1] ? UNIT_MAX : {1'b0, dv_tail.q[i][Q_BITS-2:0]};
         if (dv_tail.degen) begin
            unit_in[i] = '0;
         end else begin
            unit_in[i] = dv_tail.neg[i] ? (~sat_mag + 1'b1) : sat_mag;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= dv_tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff   <= dv_tail.tag;
         unit_ff  <= unit_in;
         degen_ff <= dv_tail.degen;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_tag    = tag_ff;
   assign rsp_unit_x     = unit_ff[0];
   assign rsp_unit_y     = unit_ff[1];
   assign rsp_unit_z     = unit_ff[2];
   assign rsp_degenerate = degen_ff;

endmodule
